[hdl/lbc_pkg.sv]
package lbc_pkg;

  localparam int SLOTS          = 8;
  localparam int SLOT_BITS      = $clog2(SLOTS);
  localparam int STAMP_BITS_DEF = 32;
  localparam int COUNT_BITS     = 32;
  localparam int DIM_BITS       = 16;
  localparam int QUEUE_DEPTH    = 4;

  localparam logic [DIM_BITS-1:0] WIDTH_RESET  = 16'd640;
  localparam logic [DIM_BITS-1:0] HEIGHT_RESET = 16'd480;

  typedef enum logic {
    REG_WIDTH  = 1'b0,
    REG_HEIGHT = 1'b1
  } reg_index_t;

  // broadcast from the top level to every cell
  typedef struct packed {
    logic                 upd;
    logic                 clr;
    logic [SLOT_BITS-1:0] slot;
    logic [7:0]           px;
  } cell_ctl_t;

  typedef struct packed {
    logic first;
    logic victim;
  } cell_stat_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       done;
  } out_entry_t;

endpackage

[hdl/lbc_cell.sv]
module lbc_cell #(
  parameter int IDX        = 0,
  parameter int STAMP_BITS = lbc_pkg::STAMP_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  lbc_pkg::cell_ctl_t        ctl,
  input  logic [STAMP_BITS-1:0]     new_stamp,
  input  logic [lbc_pkg::SLOTS-1:0] col_in,
  input  logic                      found_in,
  output logic                      found_out,
  output logic                      col_out,
  output lbc_pkg::cell_stat_t       stat
);

  localparam logic [lbc_pkg::SLOT_BITS-1:0] MY_IDX = lbc_pkg::SLOT_BITS'(IDX);

  logic [7:0]                value;
  logic [STAMP_BITS-1:0]     stamp;
  // before_row[j]: this slot is chosen ahead of slot j for replacement
  logic [lbc_pkg::SLOTS-1:0] before_row;
  logic [lbc_pkg::SLOTS-1:0] row_reset;
  logic [lbc_pkg::SLOTS-1:0] self_bit;
  logic                      match;

  always_comb begin
    row_reset = '0;
    self_bit  = '0;
    for (int j = 0; j < lbc_pkg::SLOTS; j++) begin
      row_reset[j] = (j > IDX);
    end
    self_bit[IDX] = 1'b1;
  end

  assign match          = (value == ctl.px);
  assign found_out      = found_in | match;
  assign stat.first     = match & ~found_in;
  assign stat.victim    = &(before_row | self_bit);
  assign col_out        = (stamp < new_stamp) || ((stamp == new_stamp) && (MY_IDX < ctl.slot));

  always_ff @(posedge clk) begin
    if (rst || (ctl.upd && ctl.clr)) begin
      value      <= '0;
      stamp      <= '0;
      before_row <= row_reset;
    end else if (ctl.upd) begin
      if (ctl.slot == MY_IDX) begin
        value      <= ctl.px;
        stamp      <= new_stamp;
        before_row <= ~col_in & ~self_bit;
      end else begin
        before_row[ctl.slot] <= col_out;
      end
    end
  end

endmodule

[hdl/lbc_out_queue.sv]
module lbc_out_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic [1:0]          push_n,
  input  lbc_pkg::out_entry_t e0,
  input  lbc_pkg::out_entry_t e1,
  input  logic                pop,
  output logic                space,
  output logic                head_valid,
  output lbc_pkg::out_entry_t head
);

  localparam int DEPTH = lbc_pkg::QUEUE_DEPTH;
  localparam int AW    = $clog2(DEPTH);

  lbc_pkg::out_entry_t mem [DEPTH];
  logic [AW-1:0] wp;
  logic [AW-1:0] rp;
  logic [AW:0]   cnt;

  assign head_valid = (cnt != '0);
  assign head       = mem[rp];
  assign space      = (cnt <= (AW+1)'(DEPTH - 2));

  always_ff @(posedge clk) begin
    if (push_n != 2'd0) begin
      mem[wp] <= e0;
    end
    if (push_n == 2'd2) begin
      mem[wp + AW'(1)] <= e1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= '0;
      rp  <= '0;
      cnt <= '0;
    end else begin
      wp  <= wp + AW'(push_n);
      rp  <= rp + AW'(pop);
      cnt <= cnt + (AW+1)'(push_n) - (AW+1)'(pop);
    end
  end

endmodule

[hdl/lru_byte_cache_nibble_coder_core.sv]
// Recent-value cache coder: each 8-bit pixel is looked up in an 8-slot cache
// held in a row of cells; a hit emits the slot as one nibble, a miss replaces
// the least recently stamped slot (lowest index on ties) and emits slot+8 and
// the pixel's low and high nibbles. Nibbles are packed two per byte, earlier
// nibble in bits 3..0. A pixel is looked up and cached as it is accepted,
// so pixels may enter back to back while the queue has space; output bytes
// leave through a 4-entry queue at one byte per cycle while out_ready is
// high, so hits go at one pixel per cycle and two-byte misses hold input
// back. After image_width*image_height pixels (zero counts as one) a pending
// half byte is flushed with a zero high nibble, marked image_done, and the
// cache returns to its reset state. Write the size registers only while idle.
module lru_byte_cache_nibble_coder_core #(
  parameter int STAMP_BITS = lbc_pkg::STAMP_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write,
  input  logic                          cfg_index,
  input  logic [lbc_pkg::DIM_BITS-1:0]  cfg_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [7:0]                    pixel,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [7:0]                    packed_byte,
  output logic                          last_of_run,
  output logic                          image_done
);

  localparam int SLOTS = lbc_pkg::SLOTS;
  localparam int SB    = lbc_pkg::SLOT_BITS;
  localparam int CB    = lbc_pkg::COUNT_BITS;
  localparam int DB    = lbc_pkg::DIM_BITS;

  logic [DB-1:0] width;
  logic [DB-1:0] height;
  logic [CB-1:0] total;
  logic [DB-1:0] width_next;
  logic [DB-1:0] height_next;
  logic [DB-1:0] w_eff;
  logic [DB-1:0] h_eff;

  logic [CB-1:0] count_inc;
  logic [3:0]    pend_nib;
  logic          pend_v;

  logic                accept;
  logic                done;
  logic                hit;
  logic [SB-1:0]       hit_slot;
  logic [SB-1:0]       vic_slot;
  logic [SB-1:0]       slot;
  logic [3:0]          code;
  lbc_pkg::cell_ctl_t  ctl;
  lbc_pkg::cell_stat_t stat [SLOTS];
  logic [SLOTS:0]      found;
  logic [SLOTS-1:0]    col;

  logic [1:0]          push_n;
  lbc_pkg::out_entry_t e0;
  lbc_pkg::out_entry_t e1;
  lbc_pkg::out_entry_t head;
  logic                space;

  always_comb begin
    width_next  = width;
    height_next = height;
    if (cfg_write) begin
      case (cfg_index)
        lbc_pkg::REG_WIDTH:  width_next  = cfg_data;
        lbc_pkg::REG_HEIGHT: height_next = cfg_data;
        default:             width_next  = width;
      endcase
    end
    w_eff = (width_next == '0) ? DB'(1) : width_next;
    h_eff = (height_next == '0) ? DB'(1) : height_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      width  <= lbc_pkg::WIDTH_RESET;
      height <= lbc_pkg::HEIGHT_RESET;
      total  <= CB'(lbc_pkg::WIDTH_RESET) * CB'(lbc_pkg::HEIGHT_RESET);
    end else begin
      width  <= width_next;
      height <= height_next;
      total  <= CB'(w_eff) * CB'(h_eff);
    end
  end

  assign in_ready = space;
  assign accept   = in_valid & space;
  assign done     = (count_inc >= total);

  assign found[0] = 1'b0;

  genvar gi;
  generate
    for (gi = 0; gi < SLOTS; gi++) begin : g_cell
      lbc_cell #(
        .IDX        (gi),
        .STAMP_BITS (STAMP_BITS)
      ) u_cell (
        .clk       (clk),
        .rst       (rst),
        .ctl       (ctl),
        .new_stamp (count_inc[STAMP_BITS-1:0]),
        .col_in    (col),
        .found_in  (found[gi]),
        .found_out (found[gi+1]),
        .col_out   (col[gi]),
        .stat      (stat[gi])
      );
    end
  endgenerate

  always_comb begin
    hit_slot = '0;
    vic_slot = '0;
    for (int i = 0; i < SLOTS; i++) begin
      if (stat[i].first) begin
        hit_slot = hit_slot | SB'(i);
      end
      if (stat[i].victim) begin
        vic_slot = vic_slot | SB'(i);
      end
    end
    hit  = found[SLOTS];
    slot = hit ? hit_slot : vic_slot;
    code = {~hit, slot};
    ctl.upd  = accept;
    ctl.clr  = done;
    ctl.slot = slot;
    ctl.px   = pixel;
  end

  always_comb begin
    push_n = 2'd0;
    e0     = '{data: 8'h00, last: 1'b1, done: done};
    e1     = '{data: 8'h00, last: 1'b1, done: done};
    if (hit) begin
      if (pend_v) begin
        push_n  = 2'd1;
        e0.data = {code, pend_nib};
      end else if (done) begin
        push_n  = 2'd1;
        e0.data = {4'h0, code};
      end
    end else begin
      if (pend_v) begin
        push_n  = 2'd2;
        e0.data = {code, pend_nib};
        e0.last = 1'b0;
        e0.done = 1'b0;
        e1.data = pixel;
      end else if (done) begin
        push_n  = 2'd2;
        e0.data = {pixel[3:0], code};
        e0.last = 1'b0;
        e0.done = 1'b0;
        e1.data = {4'h0, pixel[7:4]};
      end else begin
        push_n  = 2'd1;
        e0.data = {pixel[3:0], code};
      end
    end
    if (!accept) begin
      push_n = 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count_inc <= CB'(1);
      pend_nib  <= '0;
      pend_v    <= 1'b0;
    end else if (accept) begin
      if (done) begin
        count_inc <= CB'(1);
        pend_nib  <= '0;
        pend_v    <= 1'b0;
      end else begin
        count_inc <= count_inc + CB'(1);
        if (pend_v) begin
          pend_nib <= '0;
          pend_v   <= 1'b0;
        end else begin
          pend_nib <= hit ? code : pixel[7:4];
          pend_v   <= 1'b1;
        end
      end
    end
  end

  lbc_out_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_n     (push_n),
    .e0         (e0),
    .e1         (e1),
    .pop        (out_valid & out_ready),
    .space      (space),
    .head_valid (out_valid),
    .head       (head)
  );

  assign packed_byte = head.data;
  assign last_of_run = head.last;
  assign image_done  = head.done;

endmodule

[bench/nibble_code_checker.sv]
`timescale 1ns / 1ps

module nibble_code_checker (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_write,
  input  logic                         cfg_index,
  input  logic [lbc_pkg::DIM_BITS-1:0] cfg_data,
  input  logic                         in_valid,
  input  logic                         in_ready,
  input  logic [7:0]                   pixel,
  input  logic                         out_valid,
  input  logic                         out_ready,
  input  logic [7:0]                   packed_byte,
  input  logic                         last_of_run,
  input  logic                         image_done,
  output int                           errors,
  output int                           pending
);

  logic [lbc_pkg::DIM_BITS-1:0] img_w;
  logic [lbc_pkg::DIM_BITS-1:0] img_h;
  logic [7:0]                   slot_value [lbc_pkg::SLOTS];
  logic [31:0]                  slot_stamp [lbc_pkg::SLOTS];
  logic [31:0]                  pixels_seen;
  logic [3:0]                   half_nibble;
  logic                         half_full;
  logic [7:0]                   step_bytes [$];
  lbc_pkg::out_entry_t          expected_bytes [$];
  int                           bytes_out;

  function automatic void clear_image();
    int i;
    for (i = 0; i < lbc_pkg::SLOTS; i++) begin
      slot_value[i] = 8'h00;
      slot_stamp[i] = 32'd0;
    end
    pixels_seen = 32'd0;
    half_nibble = 4'h0;
    half_full   = 1'b0;
  endfunction

  function automatic void put_nibble(input logic [3:0] n);
    if (half_full) begin
      step_bytes.push_back({n, half_nibble});
      half_full   = 1'b0;
      half_nibble = 4'h0;
    end else begin
      half_nibble = n;
      half_full   = 1'b1;
    end
  endfunction

  task automatic code_pixel(input logic [7:0] px);
    int                  i;
    int                  slot;
    int                  k;
    logic [31:0]         w32;
    logic [31:0]         h32;
    logic [31:0]         total;
    logic [31:0]         least;
    bit                  finished;
    lbc_pkg::out_entry_t e;
    step_bytes.delete();
    w32 = (img_w == 0) ? 32'd1 : 32'(img_w);
    h32 = (img_h == 0) ? 32'd1 : 32'(img_h);
    total = w32 * h32;
    pixels_seen = pixels_seen + 32'd1;
    slot = -1;
    for (i = 0; i < lbc_pkg::SLOTS; i++) begin
      if (slot < 0 && slot_value[i] == px) slot = i;
    end
    if (slot >= 0) begin
      slot_stamp[slot] = pixels_seen;
      put_nibble(4'(slot));
    end else begin
      least = slot_stamp[0];
      slot = 0;
      for (i = 1; i < lbc_pkg::SLOTS; i++) begin
        if (slot_stamp[i] < least) begin
          least = slot_stamp[i];
          slot = i;
        end
      end
      slot_value[slot] = px;
      slot_stamp[slot] = pixels_seen;
      put_nibble(4'(slot + 8));
      put_nibble(px[3:0]);
      put_nibble(px[7:4]);
    end
    finished = (pixels_seen >= total);
    if (finished) begin
      // half byte left over goes out with a zero upper nibble
      if (half_full) step_bytes.push_back({4'h0, half_nibble});
      clear_image();
    end
    for (k = 0; k < step_bytes.size(); k++) begin
      e.data = step_bytes[k];
      e.last = (k == step_bytes.size() - 1);
      e.done = e.last && finished;
      expected_bytes.push_back(e);
    end
  endtask

  task automatic flag_error(input string what, input lbc_pkg::out_entry_t exp_e);
    if (errors < 10) begin
      $display("[%0t] byte %0d %s: expected data %h last %b done %b, got data %h last %b done %b",
               $realtime, bytes_out, what, exp_e.data, exp_e.last, exp_e.done,
               packed_byte, last_of_run, image_done);
    end
    errors++;
  endtask

  initial begin
    errors  = 0;
    pending = 0;
  end

  always @(posedge clk) begin
    lbc_pkg::out_entry_t e;
    if (rst) begin
      img_w = lbc_pkg::WIDTH_RESET;
      img_h = lbc_pkg::HEIGHT_RESET;
      clear_image();
      expected_bytes.delete();
      bytes_out = 0;
      errors = 0;
    end else begin
      if (cfg_write) begin
        if (cfg_index == lbc_pkg::REG_WIDTH) img_w = cfg_data;
        else img_h = cfg_data;
      end
      if (in_valid && in_ready) code_pixel(pixel);
      if (out_valid && out_ready) begin
        if (expected_bytes.size() == 0) begin
          e = '0;
          flag_error("unexpected", e);
        end else begin
          e = expected_bytes.pop_front();
          if (e.data !== packed_byte || e.last !== last_of_run || e.done !== image_done)
            flag_error("mismatch", e);
        end
        bytes_out++;
      end
    end
    pending = expected_bytes.size();
  end

endmodule

[bench/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;

  localparam int HOLD_CYCLES   = 400;
  localparam int SETTLE_CYCLES = 10;
  localparam int STALL_LIMIT   = 4000;
  localparam int PALETTE_SIZE  = 10;

  logic                         clk = 1'b0;
  logic                         rst;
  logic                         cfg_write;
  logic                         cfg_index;
  logic [lbc_pkg::DIM_BITS-1:0] cfg_data;
  logic                         in_valid;
  logic                         in_ready;
  logic [7:0]                   pixel;
  logic                         out_valid;
  logic                         out_ready;
  logic [7:0]                   packed_byte;
  logic                         last_of_run;
  logic                         image_done;
  int                           errors;
  int                           pending;

  int         tx_idle_pct = 0;
  int         rx_stall_pct = 0;
  bit         hold_start = 1'b0;
  int         quiet_cycles = 0;
  logic [7:0] palette [PALETTE_SIZE];

  always #1 clk = ~clk;

  lru_byte_cache_nibble_coder_core dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .pixel       (pixel),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .packed_byte (packed_byte),
    .last_of_run (last_of_run),
    .image_done  (image_done)
  );

  nibble_code_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .pixel       (pixel),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .packed_byte (packed_byte),
    .last_of_run (last_of_run),
    .image_done  (image_done),
    .errors      (errors),
    .pending     (pending)
  );

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  // output side: random stalls, or one long hold-off on request
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_start) begin
        hold_start = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end else begin
        out_ready <= ($urandom_range(99) >= rx_stall_pct);
      end
    end
  end

  task automatic send_pixel(input logic [7:0] v);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    pixel    <= v;
    do @(posedge clk); while (!(in_valid && in_ready));
    @(negedge clk);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input lbc_pkg::reg_index_t idx,
                           input logic [lbc_pkg::DIM_BITS-1:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_write <= 1'b0;
    @(negedge clk);
  endtask

  task automatic set_size(input logic [lbc_pkg::DIM_BITS-1:0] w,
                          input logic [lbc_pkg::DIM_BITS-1:0] h);
    write_reg(lbc_pkg::REG_WIDTH, w);
    write_reg(lbc_pkg::REG_HEIGHT, h);
  endtask

  task automatic run_phase(input logic [lbc_pkg::DIM_BITS-1:0] w,
                           input logic [lbc_pkg::DIM_BITS-1:0] h,
                           input int n, input int mode, input bit with_hold);
    int i;
    set_size(w, h);
    case (mode)
      0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
      1: begin tx_idle_pct = 75; rx_stall_pct = 0;  end
      2: begin tx_idle_pct = 0;  rx_stall_pct = 75; end
      default: begin tx_idle_pct = 13; rx_stall_pct = 13; end
    endcase
    for (i = 0; i < PALETTE_SIZE; i++) palette[i] = 8'($urandom_range(255));
    if (with_hold) hold_start = 1'b1;
    for (i = 0; i < n; i++) begin
      // mostly a small palette so hits and LRU evictions both happen
      if ($urandom_range(99) < 70) send_pixel(palette[$urandom_range(PALETTE_SIZE - 1)]);
      else send_pixel(8'($urandom_range(255)));
      if (with_hold && i == n / 2) wait_idle();
    end
    wait_idle();
  endtask

  logic [7:0] tiny_image [5]  = '{8'h00, 8'hFF, 8'h0F, 8'hF0, 8'hFF};
  logic [7:0] lru_image  [20] = '{8'h01, 8'h02, 8'h03, 8'h04, 8'h05, 8'h06, 8'h07, 8'h08,
                                  8'h01, 8'h09, 8'h02, 8'h00, 8'hFF, 8'h80, 8'h7F,
                                  8'h08, 8'h09, 8'h80, 8'h55, 8'hAA};

  initial begin
    int p;
    rst       = 1'b1;
    cfg_write = 1'b0;
    cfg_index = lbc_pkg::REG_WIDTH;
    cfg_data  = '0;
    in_valid  = 1'b0;
    pixel     = 8'h00;
    repeat (2) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // zero width counts as one: five pixels make an image
    set_size(16'd0, 16'd5);
    for (p = 0; p < 5; p++) send_pixel(tiny_image[p]);
    wait_idle();
    set_size(16'd4, 16'd5);
    for (p = 0; p < 20; p++) send_pixel(lru_image[p]);
    wait_idle();

    run_phase(16'd1, 16'd1, 60, 0, 1'b0);
    run_phase(16'd65535, 16'd1, 80, 1, 1'b0);
    run_phase(16'd1, 16'd65535, 80, 2, 1'b0);
    run_phase(16'd0, 16'd0, 40, 3, 1'b0);
    run_phase(16'd65535, 16'd65535, 60, 0, 1'b1);
    // first of these shrinks the size mid-image
    for (p = 0; p < 8; p++)
      run_phase(16'($urandom_range(6)), 16'($urandom_range(6)), 35, p % 4, 1'b0);

    wait_idle();
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
